FILE: rtl/deq_pkg.sv
// ============================================================================
// deq_pkg - shared types and constants for the double-ended queue
// Sizes, opcode and status codes, sequencer states, ring index helper.
// ============================================================================
`default_nettype none

package deq_pkg;

    // Queue geometry
    localparam int DEPTH     = 32;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SUM_W     = IDX_W + 1;

    // Transaction field widths
    localparam int OPC_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int ITEM_W   = 32;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 6;
    localparam int M_DATA_W = ((ITEM_W + FILL_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LREAD,
        S_LEMIT
    } state_t;

    // Request bundle from the sequencer to the entry store
    typedef struct packed {
        logic  wr_en;
        idx_t  wr_addr;
        word_t wr_data;
        logic  rd_en;
        idx_t  rd_addr;
    } store_req_t;

    // base + ofs modulo DEPTH, ofs below DEPTH
    function automatic idx_t ring_add(idx_t base, cnt_t ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// ============================================================================
// double_ended_queue - bounded deque of signed words on a ring buffer
// Push/pop at either end with a status transaction, or list all entries.
// ============================================================================
//
//  Channel  Dir  tdata (low bit up)       tuser         tlast
//  s_       in   value[31:0]              opcode[2:0]   -
//  m_       out  item[31:0], fill[37:32]  status[1:0]   last result of input
//
//  Push and pop: accept in S_IDLE, then in S_EXEC the pointer update and, for a
//  push, the store write. List: accept and a setup step in S_EXEC, then
//  each entry goes through the single store read port, whose data is
//  registered before it is sent.
//  A result waits in the output register; the sequencer stalls only when it
//  must load that register again while it is still full.
//  Reset clears pointers, count and the output valid; the store is not cleared.
// ============================================================================
`default_nettype none

module double_ended_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input transactions
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [deq_pkg::VALUE_W-1:0]   s_tdata,   // value
    input  logic [deq_pkg::OPC_W-1:0]     s_tuser,   // opcode
    // result transactions
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [deq_pkg::M_DATA_W-1:0]  m_tdata,   // item, fill, zero pad
    output logic [deq_pkg::STAT_W-1:0]    m_tuser,   // status
    output logic                          m_tlast    // last
);
    import deq_pkg::*;

    state_t     state_reg, state_next;
    op_t        op_reg, op_next;
    word_t      val_reg, val_next;
    idx_t       front_reg, front_next;
    cnt_t       cnt_reg, cnt_next;
    idx_t       idx_reg, idx_next;

    logic                m_valid_reg, m_valid_next;
    logic [ITEM_W-1:0]   m_item_reg, m_item_next;
    status_t             m_stat_reg, m_stat_next;
    logic [FILL_W-1:0]   m_fill_reg, m_fill_next;
    logic                m_last_reg, m_last_next;

    store_req_t store_req;
    word_t      rd_data;
    logic       out_free;
    logic       load;
    logic       is_full;
    logic       is_empty;
    logic       list_last;

    deq_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign is_full   = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty  = (cnt_reg == '0);
    assign list_last = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (op_reg)
                    OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK: begin
                        if (out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_LIST: begin
                        if (!is_empty) begin
                            state_next = S_LREAD;
                        end else if (out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LREAD: begin
                state_next = S_LEMIT;
            end
            S_LEMIT: begin
                if (out_free) begin
                    state_next = list_last ? S_IDLE : S_LREAD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready    = (state_reg == S_IDLE);
        op_next     = op_reg;
        val_next    = val_reg;
        front_next  = front_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        store_req   = '0;
        load        = 1'b0;
        m_item_next = m_item_reg;
        m_stat_next = m_stat_reg;
        m_fill_next = m_fill_reg;
        m_last_next = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next  = op_t'(s_tuser);
                    val_next = WORD_BITS'(signed'(s_tdata));
                end
            end
            S_EXEC: begin
                m_item_next = '0;
                m_last_next = 1'b1;
                m_stat_next = STAT_OK;
                case (op_reg)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (out_free) begin
                            load = 1'b1;
                            if (is_full) begin
                                m_stat_next = STAT_FULL;
                            end else begin
                                store_req.wr_en   = 1'b1;
                                store_req.wr_data = val_reg;
                                if (op_reg == OP_PUSH_FRONT) begin
                                    front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                                   : front_reg - IDX_W'(1);
                                    store_req.wr_addr = front_next;
                                end else begin
                                    store_req.wr_addr = ring_add(front_reg, cnt_reg);
                                end
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (out_free) begin
                            load = 1'b1;
                            if (is_empty) begin
                                m_stat_next = STAT_EMPTY;
                            end else begin
                                if (op_reg == OP_POP_FRONT) begin
                                    front_next = (front_reg == IDX_W'(DEPTH - 1)) ? '0
                                                 : front_reg + IDX_W'(1);
                                end
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                    end
                    OP_LIST: begin
                        idx_next = '0;
                        if (is_empty && out_free) begin
                            load        = 1'b1;
                            m_stat_next = STAT_EMPTY;
                        end
                    end
                    default: begin
                        load = 1'b0;
                    end
                endcase
                m_fill_next = FILL_W'(cnt_next);
            end
            S_LREAD: begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = ring_add(front_reg, CNT_W'(idx_reg));
            end
            S_LEMIT: begin
                if (out_free) begin
                    load        = 1'b1;
                    m_item_next = ITEM_W'(rd_data);
                    m_stat_next = STAT_OK;
                    m_fill_next = FILL_W'(cnt_reg);
                    m_last_next = list_last;
                    idx_next    = idx_reg + IDX_W'(1);
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase

        // output register handshake
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        if (load) begin
            m_item_reg <= m_item_next;
            m_stat_reg <= m_stat_next;
            m_fill_reg <= m_fill_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_fill_reg, m_item_reg});
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: rtl/deq_store.sv
// ============================================================================
// deq_store - entry store of the queue ring
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module deq_store (
    input  logic                aclk,
    input  deq_pkg::store_req_t req,
    output deq_pkg::word_t      rd_data
);
    import deq_pkg::*;

    word_t store_mem [DEPTH];
    word_t rd_data_reg;

    // write port; contents are not reset
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store_mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= store_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/deq_checker.sv
// ============================================================================
// deq_checker - port-level checks for the double-ended queue
// Watches the result channel; attached to the top level by bind.
// ============================================================================
`default_nettype none

module deq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [deq_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [deq_pkg::STAT_W-1:0]    m_tuser,
    input logic                          m_tlast
);
    import deq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // error status ends the run and carries no item
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tlast && m_tdata[ITEM_W-1:0] == '0)
        else $error("error status with item or without last");

    // a dropped push means the queue is at capacity
    a_full_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_FULL |-> m_tdata[ITEM_W+FILL_W-1:ITEM_W] == FILL_W'(DEPTH))
        else $error("full status with fill below depth");

    // an empty status reports no entries
    a_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata[ITEM_W+FILL_W-1:ITEM_W] == '0)
        else $error("empty status with nonzero fill");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/double_ended_queue_test.sv
// ============================================================================
// double_ended_queue_test - self-checking bench for the double-ended queue
// Drives push, pop, list and unused opcodes into the deque. A behavioral
// deque predicts every result transaction, which is checked field by field.
// Runs through several sender/receiver idling mixes and one long output stall.
// ============================================================================
`default_nettype none

module double_ended_queue_test;
    import deq_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int HOLD_CYCLES  = 250;
    localparam logic [OPC_W-1:0] OPC_UNUSED_LO = 3'd5;
    localparam logic [OPC_W-1:0] OPC_UNUSED_HI = 3'd7;

    typedef struct {
        logic [OPC_W-1:0]   opc;
        logic [VALUE_W-1:0] val;
    } deq_req_t;

    typedef struct {
        logic [ITEM_W-1:0] item;
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill;
        logic              last;
    } deq_rsp_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata  = '0;  // value
    logic [OPC_W-1:0]    s_tuser  = '0;  // opcode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // item, fill, zero pad
    logic [STAT_W-1:0]   m_tuser;        // status
    logic                m_tlast;        // last

    // stimulus and expectation stores
    deq_req_t req_fifo[$];
    deq_rsp_t expected_rsp[$];

    // behavioral deque
    logic [WORD_BITS-1:0] ring_words[DEPTH];
    int                   ring_front = 0;
    int                   ring_count = 0;

    // run control and statistics
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_req       = 0;
    int   hold_left      = 0;
    logic s_fire         = 1'b0;
    int   n_queued       = 0;
    int   n_taken        = 0;
    int   n_checked      = 0;
    int   n_err          = 0;
    int   n_full_drops   = 0;
    int   n_empty_rsp    = 0;
    int   max_listed     = 0;
    int   cycle_cnt      = 0;

    double_ended_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // apply one accepted request to the deque and queue up its results
    function automatic void deque_apply(input logic [OPC_W-1:0] opc,
                                        input logic [VALUE_W-1:0] val);
        deq_rsp_t r;
        int       i;
        r.item   = '0;
        r.status = STAT_OK;
        r.last   = 1'b1;
        case (opc)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (ring_count >= DEPTH) begin
                    r.status = STAT_FULL;
                    n_full_drops++;
                end else if (opc == OP_PUSH_FRONT) begin
                    ring_front = (ring_front + DEPTH - 1) % DEPTH;
                    ring_words[ring_front] = val;
                    ring_count++;
                end else begin
                    ring_words[(ring_front + ring_count) % DEPTH] = val;
                    ring_count++;
                end
                r.fill = FILL_W'(ring_count);
                expected_rsp.push_back(r);
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (ring_count == 0) begin
                    r.status = STAT_EMPTY;
                    n_empty_rsp++;
                end else begin
                    if (opc == OP_POP_FRONT) ring_front = (ring_front + 1) % DEPTH;
                    ring_count--;
                end
                r.fill = FILL_W'(ring_count);
                expected_rsp.push_back(r);
            end
            OP_LIST: begin
                r.fill = FILL_W'(ring_count);
                if (ring_count == 0) begin
                    r.status = STAT_EMPTY;
                    n_empty_rsp++;
                    expected_rsp.push_back(r);
                end else begin
                    if (ring_count > max_listed) max_listed = ring_count;
                    for (i = 0; i < ring_count; i++) begin
                        r.item = ring_words[(ring_front + i) % DEPTH];
                        r.last = (i == ring_count - 1);
                        expected_rsp.push_back(r);
                    end
                end
            end
            default: ;  // unused opcode: ignored by the block
        endcase
    endfunction

    // input driver: next request at the falling edge once the last one was taken
    always @(negedge aclk) begin
        deq_req_t q;
        if (!s_tvalid || s_fire) begin
            if (req_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                q = req_fifo.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= q.val;
                s_tuser  <= q.opc;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on accepted input, check accepted results
    always @(posedge aclk) begin
        deq_rsp_t e;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            deque_apply(s_tuser, s_tdata);
            n_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_checked++;
            if (expected_rsp.size() == 0) begin
                $error("unexpected result transaction: item %0d status %0d fill %0d",
                       $signed(m_tdata[ITEM_W-1:0]), m_tuser,
                       m_tdata[ITEM_W +: FILL_W]);
                n_err++;
            end else begin
                e = expected_rsp.pop_front();
                if (m_tdata[ITEM_W-1:0] !== e.item) begin
                    $error("item: expected %0d, got %0d",
                           $signed(e.item), $signed(m_tdata[ITEM_W-1:0]));
                    n_err++;
                end
                if (m_tuser !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_tuser);
                    n_err++;
                end
                if (m_tdata[ITEM_W +: FILL_W] !== e.fill) begin
                    $error("fill: expected %0d, got %0d", e.fill, m_tdata[ITEM_W +: FILL_W]);
                    n_err++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast);
                    n_err++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_req(input logic [OPC_W-1:0] opc, input logic [VALUE_W-1:0] val);
        deq_req_t q;
        q.opc = opc;
        q.val = val;
        req_fifo.push_back(q);
        n_queued++;
    endtask

    // wait until every request is taken and every result has come back
    task automatic wait_drained();
        while (n_taken != n_queued || expected_rsp.size() != 0) @(posedge aclk);
    endtask

    // one random request; push_pct biases toward growing or shrinking the deque
    task automatic send_random(input int push_pct);
        int                 r;
        logic [OPC_W-1:0]   opc;
        logic [VALUE_W-1:0] val;
        r = $urandom_range(99);
        if (r < 3) begin
            opc = OPC_W'($urandom_range(OPC_UNUSED_HI, OPC_UNUSED_LO));
        end else if (r < 11) begin
            opc = OP_LIST;
        end else if (r < 11 + push_pct * 89 / 100) begin
            opc = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
            opc = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        end
        case ($urandom_range(15))
            0:       val = 32'h7fff_ffff;
            1:       val = 32'h8000_0000;
            2:       val = '1;
            3:       val = '0;
            default: val = $urandom;
        endcase
        send_req(opc, val);
    endtask

    // random phase: runs of push-heavy, pop-heavy and balanced traffic
    task automatic random_phase(input int idle_pct, input int stall_pct, input int n_items);
        int left;
        int run_len;
        int push_pct;
        wait_drained();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        left = n_items;
        while (left > 0) begin
            run_len = $urandom_range(60, 20);
            if (run_len > left) run_len = left;
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            repeat (run_len) send_random(push_pct);
            left -= run_len;
        end
    endtask

    // stimulus sequence
    initial begin
        int n_held;
        int k;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, extremes, every opcode, single entry
        send_req(OP_POP_FRONT, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_LIST, '0);
        send_req(OP_PUSH_FRONT, 32'h7fff_ffff);
        send_req(OP_PUSH_BACK, 32'h8000_0000);
        send_req(OP_PUSH_FRONT, '1);
        send_req(OP_PUSH_BACK, '0);
        send_req(OP_LIST, '1);
        send_req(OPC_UNUSED_LO, 32'h1234_5678);
        send_req(OPC_UNUSED_LO + 3'd1, '1);
        send_req(OPC_UNUSED_HI, '0);
        send_req(OP_POP_FRONT, '1);
        send_req(OP_POP_BACK, '0);
        send_req(OP_LIST, '0);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_POP_BACK, '0);          // last entry leaves from the back
        send_req(OP_LIST, '0);
        send_req(OP_PUSH_BACK, 32'h5555_5555);
        send_req(OP_POP_FRONT, '0);         // last entry leaves from the front
        send_req(OP_PUSH_BACK, 32'haaaa_aaaa);
        send_req(OP_PUSH_FRONT, 32'h0000_0001);
        send_req(OP_LIST, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_BACK, '0);
        wait_drained();

        // long output stall while the deque is filled past full, listed, emptied
        n_held = ring_count;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = HOLD_CYCLES;
        for (k = 0; k < n_held; k++) send_req(OP_POP_BACK, '0);
        for (k = 0; k < DEPTH + 2; k++) begin
            send_req(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
        end
        send_req(OP_LIST, '0);
        for (k = 0; k < DEPTH + 1; k++) send_req(k[0] ? OP_POP_FRONT : OP_POP_BACK, '0);

        // random traffic under each idling mix
        random_phase(0, 0, 100);
        random_phase(52, 0, 100);
        random_phase(0, 52, 100);
        random_phase(7, 7, 100);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_rsp.size() != 0) begin
            $error("%0d result transactions never arrived", expected_rsp.size());
            n_err++;
        end

        $display("tb: %0d requests taken, %0d results checked, %0d errors",
                 n_taken, n_checked, n_err);
        $display("tb: %0d pushes dropped on full, %0d empty answers, longest listing %0d",
                 n_full_drops, n_empty_rsp, max_listed);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_store.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
tb/double_ended_queue_test.sv
